/* src/ook_remote_frame_encoder_unit_defines.svh */
// Assertion macros used by the remote frame encoder back end.
`ifndef OOK_REMOTE_FRAME_ENCODER_UNIT_DEFINES_SVH
`define OOK_REMOTE_FRAME_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OOKRFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ookrfe assertion failed");

// Next-cycle implication, checked outside reset.
`define OOKRFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ookrfe assertion failed");

`endif

/* src/ookrfe_pkg.sv */
// Types, codes and pulse timing table of the remote frame encoder.
package ookrfe_pkg;

	localparam logic [2:0] MDL_0 = 3'd0;
	localparam logic [2:0] MDL_1 = 3'd1;
	localparam logic [2:0] MDL_2 = 3'd2;
	localparam logic [2:0] MDL_3 = 3'd3;
	localparam logic [2:0] MDL_4 = 3'd4;

	localparam logic [1:0] CMD_SHOCK   = 2'd0;
	localparam logic [1:0] CMD_VIBRATE = 2'd1;
	localparam logic [1:0] CMD_SOUND   = 2'd2;
	localparam logic [1:0] CMD_LIGHT   = 2'd3;

	// Type codes of model 3 (high nibble before the device id, low nibble after the intensity).
	localparam logic [7:0] M3_CODE_SHOCK   = 8'h61;
	localparam logic [7:0] M3_CODE_VIBRATE = 8'h72;
	localparam logic [7:0] M3_CODE_SOUND   = 8'h84;

	// Leading byte of every model 4 frame.
	localparam logic [7:0] M4_FRAME_MARK = 8'h04;

	localparam int FRAME_W = 43;

	typedef struct packed {
		logic [2:0]  model;
		logic [1:0]  command;
		logic [15:0] device_id;
		logic [7:0]  intensity;
		logic [7:0]  channel;
	} in_item_t;

	typedef struct packed {
		logic [10:0] high_us;
		logic [12:0] low_us;
		logic        last;
		logic        rejected;
	} out_item_t;

	// Encoded command as it travels from front end to back end.
	typedef struct packed {
		logic               rejected;
		logic [2:0]         model;
		logic [5:0]         nbits;
		logic [FRAME_W-1:0] data;
	} frame_t;

	typedef struct packed {
		logic [10:0] hi;
		logic [12:0] lo;
	} pulse_t;

	typedef enum logic [1:0] {
		PK_PRE,
		PK_ONE,
		PK_ZERO,
		PK_POST
	} pulse_kind_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_BITS,
		PH_POST
	} phase_t;

	function automatic pulse_t pulse_lookup(input logic [2:0] model, input pulse_kind_t kind);
		pulse_t p;
		p = '{hi: 11'd0, lo: 13'd0};
		case (model)
			MDL_0: begin
				case (kind)
					PK_PRE:  p = '{hi: 11'd1400, lo: 13'd750};
					PK_ONE:  p = '{hi: 11'd750,  lo: 13'd250};
					PK_ZERO: p = '{hi: 11'd250,  lo: 13'd750};
					default: p = '{hi: 11'd0,    lo: 13'd0};
				endcase
			end
			MDL_1: begin
				case (kind)
					PK_PRE:  p = '{hi: 11'd750, lo: 13'd750};
					PK_ONE:  p = '{hi: 11'd200, lo: 13'd1500};
					PK_ZERO: p = '{hi: 11'd200, lo: 13'd750};
					default: p = '{hi: 11'd200, lo: 13'd7000};
				endcase
			end
			MDL_2: begin
				case (kind)
					PK_PRE:  p = '{hi: 11'd1500, lo: 13'd750};
					PK_ONE:  p = '{hi: 11'd750,  lo: 13'd250};
					PK_ZERO: p = '{hi: 11'd250,  lo: 13'd750};
					default: p = '{hi: 11'd250,  lo: 13'd3750};
				endcase
			end
			MDL_3: begin
				case (kind)
					PK_PRE:  p = '{hi: 11'd960, lo: 13'd790};
					PK_ONE:  p = '{hi: 11'd220, lo: 13'd980};
					PK_ZERO: p = '{hi: 11'd220, lo: 13'd580};
					default: p = '{hi: 11'd220, lo: 13'd135};
				endcase
			end
			MDL_4: begin
				case (kind)
					PK_PRE:  p = '{hi: 11'd1900, lo: 13'd4000};
					PK_ONE:  p = '{hi: 11'd900,  lo: 13'd300};
					PK_ZERO: p = '{hi: 11'd300,  lo: 13'd900};
					default: p = '{hi: 11'd200,  lo: 13'd2200};
				endcase
			end
			default: p = '{hi: 11'd0, lo: 13'd0};
		endcase
		return p;
	endfunction

endpackage

/* src/ookrfe_front.sv */
// Front end: register one command, classify it and pack its frame bits.
module ookrfe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  ookrfe_pkg::in_item_t  cmd,
	output logic                  push,
	input  logic                  push_ready,
	output ookrfe_pkg::frame_t    frame
);

	localparam logic [63:0] NIBBLE_CHECK_TABLE = 64'h084C2A6E195D3B7F;

	function automatic logic [3:0] nibble_check(input logic [3:0] b);
		return NIBBLE_CHECK_TABLE[{b, 2'b00} +: 4];
	endfunction

	function automatic logic [7:0] byte_sum(input logic [31:0] w);
		return w[7:0] + w[15:8] + w[23:16] + w[31:24];
	endfunction

	logic                 valid_s1;
	ookrfe_pkg::in_item_t item_s1;

	logic        is_sound;
	logic [7:0]  inten_c99;
	logic [7:0]  inten_c100;
	logic [7:0]  inten0;
	logic [7:0]  inten3;
	logic [3:0]  cmd_p1;
	logic [11:0] prod15;
	logic [24:0] recip;
	logic [5:0]  scaled;
	logic [3:0]  inten4;
	logic [1:0]  chan4;
	logic [31:0] payload0;
	logic [31:0] payload4;
	logic [7:0]  tv1;
	logic [7:0]  ts1;
	logic [3:0]  tv2;
	logic [3:0]  ch2;
	logic [7:0]  tv3;
	logic [3:0]  ch3;

	assign cmd_ready = !valid_s1 || push_ready;
	assign push      = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1 <= cmd;
		end
	end

	always_comb begin
		is_sound   = (item_s1.command == ookrfe_pkg::CMD_SOUND);
		inten_c99  = (item_s1.intensity > 8'd99) ? 8'd99 : item_s1.intensity;
		inten_c100 = (item_s1.intensity > 8'd100) ? 8'd100 : item_s1.intensity;
		inten0     = is_sound ? 8'd0 : inten_c99;
		inten3     = is_sound ? 8'd0 : inten_c100;
		cmd_p1     = {2'b00, item_s1.command} + 4'd1;

		// intensity * 15 / 100 via reciprocal 5243 / 2^19, exact below 4096
		prod15 = {item_s1.intensity, 4'b0000} - {4'b0000, item_s1.intensity};
		recip  = {13'd0, prod15} * 25'd5243;
		scaled = recip[24:19];
		if (is_sound || item_s1.intensity == 8'd0) begin
			inten4 = 4'd0;
		end else if (scaled > 6'd15) begin
			inten4 = 4'd15;
		end else if (scaled == 6'd0) begin
			inten4 = 4'd1;
		end else begin
			inten4 = scaled[3:0];
		end
		if (item_s1.channel == 8'd0) begin
			chan4 = 2'd1;
		end else if (item_s1.channel > 8'd3) begin
			chan4 = 2'd3;
		end else begin
			chan4 = item_s1.channel[1:0];
		end

		payload0 = {item_s1.device_id, item_s1.channel[3:0], cmd_p1, inten0};
		payload4 = {ookrfe_pkg::M4_FRAME_MARK, item_s1.device_id, cmd_p1[1:0], chan4, inten4};

		tv1 = 8'h80 | (8'h01 << item_s1.command);
		ts1 = ~(8'h01 | (8'h80 >> item_s1.command));

		tv2 = 4'h1 << item_s1.command;
		ch2 = (item_s1.channel == 8'd0) ? 4'h8 : 4'hF;

		case (item_s1.command)
			ookrfe_pkg::CMD_SHOCK:   tv3 = ookrfe_pkg::M3_CODE_SHOCK;
			ookrfe_pkg::CMD_VIBRATE: tv3 = ookrfe_pkg::M3_CODE_VIBRATE;
			default:                 tv3 = ookrfe_pkg::M3_CODE_SOUND;
		endcase
		ch3 = (item_s1.channel == 8'd0) ? 4'h0 : 4'hE;

		frame.model    = item_s1.model;
		frame.rejected = 1'b0;
		frame.nbits    = 6'd40;
		frame.data     = '0;
		case (item_s1.model)
			ookrfe_pkg::MDL_0: begin
				frame.nbits = 6'd43;
				frame.data  = {payload0, byte_sum(payload0), 3'b000};
			end
			ookrfe_pkg::MDL_1: begin
				frame.rejected = (item_s1.command == ookrfe_pkg::CMD_LIGHT);
				frame.data     = {tv1, item_s1.device_id, inten_c100, ts1, 3'b000};
			end
			ookrfe_pkg::MDL_2: begin
				frame.data = {ch2, tv2, item_s1.device_id, inten_c100,
					nibble_check(tv2), nibble_check(ch2), 3'b000};
			end
			ookrfe_pkg::MDL_3: begin
				frame.rejected = (item_s1.command == ookrfe_pkg::CMD_LIGHT);
				frame.nbits    = 6'd41;
				frame.data     = {ch3, tv3[7:4], item_s1.device_id, inten3,
					tv3[3:0], ch3, 1'b0, 2'b00};
			end
			ookrfe_pkg::MDL_4: begin
				frame.rejected = (item_s1.command == ookrfe_pkg::CMD_LIGHT);
				frame.data     = {payload4, byte_sum(payload4), 3'b000};
			end
			default: begin
				frame.rejected = 1'b1;
			end
		endcase
	end

endmodule

/* src/ookrfe_queue.sv */
// Small FIFO of encoded frames between front end and back end.
module ookrfe_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               push_ready,
	input  ookrfe_pkg::frame_t push_data,
	input  logic               pop,
	output logic               pop_valid,
	output ookrfe_pkg::frame_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	ookrfe_pkg::frame_t entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* src/ookrfe_back.sv */
// Back end: walk one frame and emit its pulses into the output register.
`include "ook_remote_frame_encoder_unit_defines.svh"

module ookrfe_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  ookrfe_pkg::frame_t    q_data,
	output logic                  pulse_valid,
	input  logic                  pulse_ready,
	output ookrfe_pkg::out_item_t pulse
);

	localparam int FW = ookrfe_pkg::FRAME_W;

	ookrfe_pkg::phase_t    state_q, state_d;
	logic [FW-1:0]         data_q, data_d;
	logic [5:0]            cnt_q, cnt_d;
	logic [2:0]            model_q, model_d;
	logic                  out_valid_q;
	ookrfe_pkg::out_item_t out_q, out_d;
	logic                  adv;
	logic                  emit;
	ookrfe_pkg::pulse_t    p;

	assign adv         = !out_valid_q || pulse_ready;
	assign pulse_valid = out_valid_q;
	assign pulse       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ookrfe_pkg::PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pulse_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		data_q  <= data_d;
		cnt_q   <= cnt_d;
		model_q <= model_d;
		if (emit) begin
			out_q <= out_d;
		end
	end

	always_comb begin
		state_d = state_q;
		data_d  = data_q;
		cnt_d   = cnt_q;
		model_d = model_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		p       = '{hi: 11'd0, lo: 13'd0};
		out_d   = '{high_us: 11'd0, low_us: 13'd0, last: 1'b0, rejected: 1'b0};
		case (state_q)
			ookrfe_pkg::PH_IDLE: begin
				if (adv && q_valid) begin
					q_pop = 1'b1;
					emit  = 1'b1;
					if (q_data.rejected) begin
						out_d.last     = 1'b1;
						out_d.rejected = 1'b1;
					end else begin
						p             = ookrfe_pkg::pulse_lookup(q_data.model, ookrfe_pkg::PK_PRE);
						out_d.high_us = p.hi;
						out_d.low_us  = p.lo;
						state_d       = ookrfe_pkg::PH_BITS;
						data_d        = q_data.data;
						cnt_d         = q_data.nbits;
						model_d       = q_data.model;
					end
				end
			end
			ookrfe_pkg::PH_BITS: begin
				if (adv) begin
					emit = 1'b1;
					p    = ookrfe_pkg::pulse_lookup(model_q,
						data_q[FW-1] ? ookrfe_pkg::PK_ONE : ookrfe_pkg::PK_ZERO);
					out_d.high_us = p.hi;
					out_d.low_us  = p.lo;
					data_d        = {data_q[FW-2:0], 1'b0};
					cnt_d         = cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						if (model_q == ookrfe_pkg::MDL_0) begin
							out_d.last = 1'b1;
							state_d    = ookrfe_pkg::PH_IDLE;
						end else begin
							state_d = ookrfe_pkg::PH_POST;
						end
					end
				end
			end
			ookrfe_pkg::PH_POST: begin
				if (adv) begin
					emit          = 1'b1;
					p             = ookrfe_pkg::pulse_lookup(model_q, ookrfe_pkg::PK_POST);
					out_d.high_us = p.hi;
					out_d.low_us  = p.lo;
					out_d.last    = 1'b1;
					state_d       = ookrfe_pkg::PH_IDLE;
				end
			end
			default: begin
				state_d = ookrfe_pkg::PH_IDLE;
			end
		endcase
	end

	`OOKRFE_ASSERT_NOW(a_pop_needs_entry, clk, arst_n, q_pop, q_valid)
	`OOKRFE_ASSERT_NEXT(a_accepted_frame_walks_bits, clk, arst_n, q_pop && !q_data.rejected, state_q == ookrfe_pkg::PH_BITS && cnt_q != 6'd0)
	`OOKRFE_ASSERT_NOW(a_reject_is_lone_zero_item, clk, arst_n, out_valid_q && out_q.rejected, out_q.last && out_q.high_us == 11'd0 && out_q.low_us == 13'd0)

endmodule

/* src/ook_remote_frame_encoder_unit.sv */
// Top level of the on-off-keyed remote frame encoder.
//
// Each command transfer (model, command, device id, intensity, channel) turns into
// one pulse train of 42 to 44 (high_us, low_us) transfers, preamble first, frame
// bits most significant first, then a postamble on every model but model 0; last
// marks the final pulse. An unsupported model/command pair gives a single transfer
// with rejected and last set and both durations zero. The front end registers the
// command and packs its frame combinationally from that register; the back end
// emits one pulse per cycle from a registered output while the receiver is ready.
// With the queue and the output empty, the first pulse passes the front end
// register, a queue entry and the output register before it is presented.
// QUEUE_DEPTH encoded frames wait between the two halves, so new commands keep
// being taken while a train plays out.
module ook_remote_frame_encoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  ookrfe_pkg::in_item_t  cmd,
	output logic                  pulse_valid,
	input  logic                  pulse_ready,
	output ookrfe_pkg::out_item_t pulse
);

	// Encoded frame handoff, front end to queue.
	logic               push;
	logic               push_ready;
	ookrfe_pkg::frame_t push_frame;

	// Queue head, consumed by the back end.
	logic               q_valid;
	logic               q_pop;
	ookrfe_pkg::frame_t q_frame;

	// Classify the command and pack its frame bits.
	ookrfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.push       (push),
		.push_ready (push_ready),
		.frame      (push_frame)
	);

	// Hold frames so front and back stall independently.
	ookrfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_frame),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_data   (q_frame)
	);

	// Advance through the frame one pulse per output transfer.
	ookrfe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_data      (q_frame),
		.pulse_valid (pulse_valid),
		.pulse_ready (pulse_ready),
		.pulse       (pulse)
	);

endmodule

/* test/ook_remote_frame_encoder_unit_test.sv */
// Self-checking testbench for the on-off-keyed remote frame encoder.
`timescale 1ns / 1ps

class pulse_train_checker;
	ookrfe_pkg::out_item_t expected_pulses[$];
	int unsigned mismatch_count;
	int unsigned pulse_count;
	int unsigned train_count;
	int unsigned reject_count;

	static function logic [7:0] byte_sum(logic [31:0] w);
		return w[7:0] + w[15:8] + w[23:16] + w[31:24];
	endfunction

	// Reverse the bit order of a nibble, then invert it.
	static function logic [3:0] nibble_check(logic [3:0] n);
		return ~{n[0], n[1], n[2], n[3]};
	endfunction

	static function void model_timing(input logic [2:0] m, output ookrfe_pkg::pulse_t pre,
			output ookrfe_pkg::pulse_t one, output ookrfe_pkg::pulse_t zero,
			output ookrfe_pkg::pulse_t post, output bit has_post);
		has_post = 1'b1;
		pre = '{11'd0, 13'd0};
		one = '{11'd0, 13'd0};
		zero = '{11'd0, 13'd0};
		post = '{11'd0, 13'd0};
		case (m)
			ookrfe_pkg::MDL_0: begin
				pre = '{11'd1400, 13'd750};
				one = '{11'd750, 13'd250};
				zero = '{11'd250, 13'd750};
				has_post = 1'b0;
			end
			ookrfe_pkg::MDL_1: begin
				pre = '{11'd750, 13'd750};
				one = '{11'd200, 13'd1500};
				zero = '{11'd200, 13'd750};
				post = '{11'd200, 13'd7000};
			end
			ookrfe_pkg::MDL_2: begin
				pre = '{11'd1500, 13'd750};
				one = '{11'd750, 13'd250};
				zero = '{11'd250, 13'd750};
				post = '{11'd250, 13'd3750};
			end
			ookrfe_pkg::MDL_3: begin
				pre = '{11'd960, 13'd790};
				one = '{11'd220, 13'd980};
				zero = '{11'd220, 13'd580};
				post = '{11'd220, 13'd135};
			end
			default: begin
				pre = '{11'd1900, 13'd4000};
				one = '{11'd900, 13'd300};
				zero = '{11'd300, 13'd900};
				post = '{11'd200, 13'd2200};
			end
		endcase
	endfunction

	// Encode one accepted command and queue the pulse train it must produce.
	function void note_command(ookrfe_pkg::in_item_t c);
		logic [63:0]        frame;
		logic [31:0]        word;
		logic [7:0]         lvl;
		logic [7:0]         tv;
		logic [7:0]         ts;
		logic [3:0]         tn;
		logic [3:0]         cn;
		int                 nbits;
		int                 scaled;
		int                 chan;
		bit                 ok;
		bit                 has_post;
		ookrfe_pkg::pulse_t pre, one, zero, post, p;

		frame = '0;
		nbits = 0;
		ok = 1'b1;
		lvl = c.intensity;
		train_count++;
		case (c.model)
			ookrfe_pkg::MDL_0: begin
				if (lvl > 99) lvl = 8'd99;
				if (c.command == ookrfe_pkg::CMD_SOUND) lvl = 8'd0;
				word = {c.device_id, c.channel[3:0], {2'b00, c.command} + 4'd1, lvl};
				frame = {word, byte_sum(word), 3'b000};
				nbits = 43;
			end
			ookrfe_pkg::MDL_1: begin
				if (c.command == ookrfe_pkg::CMD_LIGHT) begin
					ok = 1'b0;
				end else begin
					if (lvl > 100) lvl = 8'd100;
					tv = 8'h80 | (8'd1 << c.command);
					ts = ~(8'h01 | (8'h80 >> c.command));
					frame = {tv, c.device_id, lvl, ts};
					nbits = 40;
				end
			end
			ookrfe_pkg::MDL_2: begin
				tn = 4'd1 << c.command;
				cn = (c.channel == 8'd0) ? 4'h8 : 4'hF;
				if (lvl > 100) lvl = 8'd100;
				frame = {cn, tn, c.device_id, lvl, nibble_check(tn), nibble_check(cn)};
				nbits = 40;
			end
			ookrfe_pkg::MDL_3: begin
				if (c.command == ookrfe_pkg::CMD_LIGHT) begin
					ok = 1'b0;
				end else begin
					cn = (c.channel == 8'd0) ? 4'h0 : 4'hE;
					if (lvl > 100) lvl = 8'd100;
					case (c.command)
						ookrfe_pkg::CMD_SHOCK:   tv = ookrfe_pkg::M3_CODE_SHOCK;
						ookrfe_pkg::CMD_VIBRATE: tv = ookrfe_pkg::M3_CODE_VIBRATE;
						default:                 tv = ookrfe_pkg::M3_CODE_SOUND;
					endcase
					if (c.command == ookrfe_pkg::CMD_SOUND) lvl = 8'd0;
					frame = {cn, tv[7:4], c.device_id, lvl, tv[3:0], cn, 1'b0};
					nbits = 41;
				end
			end
			ookrfe_pkg::MDL_4: begin
				if (c.command == ookrfe_pkg::CMD_LIGHT) begin
					ok = 1'b0;
				end else begin
					scaled = 0;
					if (c.command != ookrfe_pkg::CMD_SOUND && lvl != 8'd0) begin
						scaled = int'(lvl) * 15 / 100;
						if (scaled < 1) scaled = 1;
						if (scaled > 15) scaled = 15;
					end
					chan = int'(c.channel);
					if (chan < 1) chan = 1;
					if (chan > 3) chan = 3;
					word = {ookrfe_pkg::M4_FRAME_MARK, c.device_id, 2'(c.command + 2'd1),
						2'(chan), 4'(scaled)};
					frame = {word, byte_sum(word)};
					nbits = 40;
				end
			end
			default: ok = 1'b0;
		endcase

		if (!ok) begin
			reject_count++;
			expected_pulses.push_back('{high_us: 11'd0, low_us: 13'd0, last: 1'b1,
				rejected: 1'b1});
			return;
		end

		model_timing(c.model, pre, one, zero, post, has_post);
		expected_pulses.push_back('{high_us: pre.hi, low_us: pre.lo, last: 1'b0,
			rejected: 1'b0});
		for (int i = nbits - 1; i >= 0; i--) begin
			p = frame[i] ? one : zero;
			expected_pulses.push_back('{high_us: p.hi, low_us: p.lo,
				last: (!has_post && i == 0), rejected: 1'b0});
		end
		if (has_post)
			expected_pulses.push_back('{high_us: post.hi, low_us: post.lo, last: 1'b1,
				rejected: 1'b0});
	endfunction

	function void report_mismatch(string what, ookrfe_pkg::out_item_t want,
			ookrfe_pkg::out_item_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected hi=%0d lo=%0d last=%0b rej=%0b, %s",
				$realtime, what, want.high_us, want.low_us, want.last, want.rejected,
				$sformatf("got hi=%0d lo=%0d last=%0b rej=%0b",
					got.high_us, got.low_us, got.last, got.rejected));
	endfunction

	// Compare one accepted pulse with the oldest pending expectation.
	function void check_pulse(ookrfe_pkg::out_item_t got);
		ookrfe_pkg::out_item_t want;
		pulse_count++;
		if (expected_pulses.size() == 0) begin
			report_mismatch("pulse with nothing pending", '0, got);
			return;
		end
		want = expected_pulses.pop_front();
		if (got.high_us !== want.high_us || got.low_us !== want.low_us ||
				got.last !== want.last || got.rejected !== want.rejected)
			report_mismatch("pulse mismatch", want, got);
	endfunction
endclass

module ook_remote_frame_encoder_unit_test;

	logic                  clk;
	logic                  arst_n;
	logic                  cmd_valid;
	logic                  cmd_ready;
	ookrfe_pkg::in_item_t  cmd;
	logic                  pulse_valid;
	logic                  pulse_ready;
	ookrfe_pkg::out_item_t pulse;

	// Chance of an idle burst per transfer is 1 in idle_odds; zero disables idling.
	int unsigned idle_odds;

	pulse_train_checker board = new();

	// Intensity values around the clamp and scaling thresholds.
	logic [7:0] lvl_edges [10] = '{8'd0, 8'd1, 8'd6, 8'd7, 8'd99, 8'd100, 8'd101,
		8'd106, 8'd107, 8'd255};

	ook_remote_frame_encoder_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.pulse_valid (pulse_valid),
		.pulse_ready (pulse_ready),
		.pulse       (pulse)
	);

	always #5 clk = ~clk;

	// Check every pulse transfer; values are the ones present before the edge.
	always @(posedge clk) begin
		if (arst_n && pulse_valid && pulse_ready)
			board.check_pulse(pulse);
	end

	// Drive one command and hold it until the transfer happens. Valid stays high
	// into the next command unless an idle burst drops it first.
	task automatic send_command(input logic [2:0] m, input logic [1:0] c,
			input logic [15:0] id, input logic [7:0] lvl, input logic [7:0] ch);
		ookrfe_pkg::in_item_t item;
		item = '{model: m, command: c, device_id: id, intensity: lvl, channel: ch};
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		cmd <= item;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		// Record the command in this process so the end-of-run drain sees it.
		board.note_command(item);
	endtask

	// Receiver: stall in random bursts while idling is enabled, else always ready.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				pulse_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			pulse_ready <= 1'b1;
		end
	end

	// Stop a hung run; the bound is several times the slowest legal run.
	initial begin
		#20_000_000;
		$display("ook_remote_frame_encoder_unit regression: fail");
		$finish;
	end

	initial begin
		int unsigned seg_odds [7];
		logic [2:0]  m;
		logic [7:0]  lvl;
		logic [7:0]  ch;

		seg_odds = '{3, 0, 2, 8, 0, 4, 0};
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		pulse_ready = 1'b0;
		idle_odds = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: every model and command, field extremes, clamp and scaling
		// edges, sound forcing zero intensity, light on models 1, 3, 4 and models 5 to 7.
		idle_odds = 3;
		send_command(ookrfe_pkg::MDL_0, ookrfe_pkg::CMD_SHOCK,   16'h0000, 8'd0,   8'h00);
		send_command(ookrfe_pkg::MDL_0, ookrfe_pkg::CMD_VIBRATE, 16'hFFFF, 8'd99,  8'hFF);
		send_command(ookrfe_pkg::MDL_0, ookrfe_pkg::CMD_SOUND,   16'h1234, 8'd200, 8'h05);
		send_command(ookrfe_pkg::MDL_0, ookrfe_pkg::CMD_LIGHT,   16'hA5A5, 8'd255, 8'h0F);
		send_command(ookrfe_pkg::MDL_1, ookrfe_pkg::CMD_SHOCK,   16'hFFFF, 8'd100, 8'h00);
		send_command(ookrfe_pkg::MDL_1, ookrfe_pkg::CMD_VIBRATE, 16'h0000, 8'd101, 8'hFF);
		send_command(ookrfe_pkg::MDL_1, ookrfe_pkg::CMD_SOUND,   16'h5A5A, 8'd255, 8'h01);
		send_command(ookrfe_pkg::MDL_1, ookrfe_pkg::CMD_LIGHT,   16'h1111, 8'd50,  8'h01);
		send_command(ookrfe_pkg::MDL_2, ookrfe_pkg::CMD_SHOCK,   16'h0000, 8'd0,   8'h00);
		send_command(ookrfe_pkg::MDL_2, ookrfe_pkg::CMD_VIBRATE, 16'hFFFF, 8'd100, 8'h01);
		send_command(ookrfe_pkg::MDL_2, ookrfe_pkg::CMD_SOUND,   16'hC3C3, 8'd255, 8'hFF);
		send_command(ookrfe_pkg::MDL_2, ookrfe_pkg::CMD_LIGHT,   16'h8001, 8'd42,  8'h00);
		send_command(ookrfe_pkg::MDL_3, ookrfe_pkg::CMD_SHOCK,   16'h0001, 8'd100, 8'h00);
		send_command(ookrfe_pkg::MDL_3, ookrfe_pkg::CMD_VIBRATE, 16'hFFFE, 8'd255, 8'hFF);
		send_command(ookrfe_pkg::MDL_3, ookrfe_pkg::CMD_SOUND,   16'h7E7E, 8'd200, 8'h01);
		send_command(ookrfe_pkg::MDL_3, ookrfe_pkg::CMD_LIGHT,   16'h2222, 8'd10,  8'h01);
		send_command(ookrfe_pkg::MDL_4, ookrfe_pkg::CMD_SHOCK,   16'h0000, 8'd0,   8'h00);
		send_command(ookrfe_pkg::MDL_4, ookrfe_pkg::CMD_SHOCK,   16'hFFFF, 8'd1,   8'h02);
		send_command(ookrfe_pkg::MDL_4, ookrfe_pkg::CMD_VIBRATE, 16'h1357, 8'd106, 8'h03);
		send_command(ookrfe_pkg::MDL_4, ookrfe_pkg::CMD_VIBRATE, 16'h2468, 8'd107, 8'hFF);
		send_command(ookrfe_pkg::MDL_4, ookrfe_pkg::CMD_SOUND,   16'hBEEF, 8'd255, 8'h01);
		send_command(ookrfe_pkg::MDL_4, ookrfe_pkg::CMD_LIGHT,   16'h3333, 8'd60,  8'h02);
		send_command(3'd5, ookrfe_pkg::CMD_SHOCK, 16'h4444, 8'd20,  8'h01);
		send_command(3'd6, ookrfe_pkg::CMD_SOUND, 16'hFFFF, 8'd255, 8'hFF);
		send_command(3'd7, ookrfe_pkg::CMD_LIGHT, 16'h0000, 8'd0,   8'h00);

		// Random: mostly supported models with content biased toward the edges.
		// Idling varies per segment; the last segment runs with none.
		for (int seg = 0; seg < 7; seg++) begin
			idle_odds = seg_odds[seg];
			for (int n = 0; n < 40; n++) begin
				m = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
					: 3'($urandom_range(0, 4));
				lvl = ($urandom_range(0, 3) == 0) ? lvl_edges[$urandom_range(0, 9)]
					: 8'($urandom_range(0, 255));
				ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 4))
					: 8'($urandom_range(0, 255));
				send_command(m, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
					lvl, ch);
			end
		end
		cmd_valid <= 1'b0;

		// Drain all pending pulses, then watch a while for stray transfers.
		while (board.expected_pulses.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("covered %0d commands over all models and commands (%0d rejected)",
			board.train_count, board.reject_count);
		$display("checked %0d pulse transfers, %0d mismatches",
			board.pulse_count, board.mismatch_count);
		if (board.mismatch_count == 0 && board.expected_pulses.size() == 0) begin
			$display("ook_remote_frame_encoder_unit regression: pass");
		end else begin
			$display("ook_remote_frame_encoder_unit regression: fail");
		end
		$finish;
	end

endmodule

/* ook_remote_frame_encoder_unit.f */
+incdir+src
src/ookrfe_pkg.sv
src/ookrfe_front.sv
src/ookrfe_queue.sv
src/ookrfe_back.sv
src/ook_remote_frame_encoder_unit.sv
test/ook_remote_frame_encoder_unit_test.sv
